// ----- rtl/sms_pkg.sv -----
// Package for the stable merge sorter: payload structs, command codes, FSM states.
// Used by every module of the block; it depends on nothing else.
package sms_pkg;

	localparam int MAX_RECORDS_DEF = 64;
	localparam int KEY_BITS_DEF    = 32;
	localparam int QUEUE_DEPTH     = 4;

	// Configuration register indexes.
	localparam logic [1:0] CFG_DESCENDING = 2'd0;
	localparam logic [1:0] CFG_SIGNED     = 2'd1;

	typedef struct packed {
		logic [31:0] item_key;
		logic [31:0] item_payload;
		logic        item_last;
	} in_item_t;

	typedef struct packed {
		logic [31:0] sorted_key;
		logic [31:0] sorted_payload;
		logic        sorted_last;
		logic        batch_overflowed;
	} out_item_t;

	typedef struct packed {
		logic [31:0] key;
		logic [31:0] payload;
	} record_t;

	typedef enum logic [1:0] {
		CMD_STORE,
		CMD_STORE_LAST,
		CMD_END
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic      ovf;
		record_t   rec;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic descending_order;
		logic signed_keys;
	} cfg_t;

	typedef enum logic [2:0] {
		BK_LOAD,
		BK_BLOCK,
		BK_READ,
		BK_MERGE,
		BK_EMIT
	} back_state_t;

endpackage

// ----- rtl/sms_front.sv -----
// Front end of the stable merge sorter: takes items, counts the batch and turns each
// item that fits, and the last, into a command for the back end. Depends on sms_pkg.
module sms_front import sms_pkg::*; #(
	parameter int MAX_RECORDS = MAX_RECORDS_DEF,
	parameter int KEY_BITS    = KEY_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  in_item_t item,
	output logic     busy,
	input  q_stat_t  q_stat,
	input  logic     back_done,
	output logic     push,
	output cmd_t     cmd
);

	localparam int CW = $clog2(MAX_RECORDS + 1);
	localparam logic [31:0] KEY_MASK = 32'((64'd1 << KEY_BITS) - 64'd1);

	logic [CW-1:0] cnt_q;
	logic          ovf_q;
	logic          wait_q;
	logic          accept;
	logic          room;

	assign busy   = wait_q | q_stat.full;
	assign accept = start & ~busy;
	assign room   = cnt_q < CW'(MAX_RECORDS);
	assign push   = accept & (room | item.item_last);

	always_comb begin
		if (!room) begin
			cmd.kind = CMD_END;
		end else if (item.item_last) begin
			cmd.kind = CMD_STORE_LAST;
		end else begin
			cmd.kind = CMD_STORE;
		end
		cmd.ovf         = ovf_q | ~room;
		cmd.rec.key     = item.item_key & KEY_MASK;
		cmd.rec.payload = item.item_payload;
	end

	// The front holds off new items from the last transfer of a batch until
	// the back end has issued the read of the final record of the sorted batch.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			ovf_q  <= 1'b0;
			wait_q <= 1'b0;
		end else begin
			if (accept) begin
				if (item.item_last) begin
					cnt_q  <= '0;
					ovf_q  <= 1'b0;
					wait_q <= 1'b1;
				end else if (room) begin
					cnt_q <= cnt_q + 1'b1;
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (back_done) begin
				wait_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/sms_queue.sv -----
// Short command queue between the front and back ends of the sorter.
// Depends on sms_pkg for the command type.
module sms_queue import sms_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  cmd_t    push_cmd,
	input  logic    pop,
	output cmd_t    head,
	output q_stat_t stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	cmd_t          entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] fill_q;

	assign head       = entry_q[rd_ptr_q];
	assign stat.full  = fill_q == NW'(DEPTH);
	assign stat.empty = fill_q == '0;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/sms_back.sv -----
// Back end of the sorter: record memories, bottom-up stable merge passes and the
// result stage. Depends on sms_pkg.
module sms_back import sms_pkg::*; #(
	parameter int MAX_RECORDS = MAX_RECORDS_DEF,
	parameter int KEY_BITS    = KEY_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  q_stat_t   q_stat,
	input  cmd_t      head,
	output logic      pop,
	output logic      done,
	output logic      result_valid,
	output out_item_t result
);

	localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
	localparam int CW = $clog2(MAX_RECORDS + 1);
	localparam int SW = CW + 1;
	localparam logic [KEY_BITS-1:0] SIGN_MASK = KEY_BITS'(1) << (KEY_BITS - 1);

	// Two record memories used in turn as source and destination of a pass.
	record_t mem_a [MAX_RECORDS];
	record_t mem_b [MAX_RECORDS];

	back_state_t   state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [CW-1:0] n_q, n_d;
	logic [CW-1:0] lo_q, lo_d;
	logic [CW-1:0] mid_q, mid_d;
	logic [CW-1:0] hi_q, hi_d;
	logic [CW-1:0] l_q, l_d;
	logic [CW-1:0] r_q, r_d;
	logic [CW-1:0] o_q, o_d;
	logic [CW-1:0] k_q, k_d;
	logic [CW-1:0] w_q, w_d;
	logic          p_q, p_d;
	logic          ovf_q, ovf_d;

	logic          emit_vld_s1, emit_last_s1, emit_ovf_s1;
	logic          emit_go, emit_last;
	logic          result_valid_q;
	out_item_t     result_q;

	record_t       rd_a_l_q, rd_a_r_q, rd_b_l_q, rd_b_r_q;
	record_t       sel_l, sel_r, wr_rec;
	logic [AW-1:0] addr_l, addr_r, wr_addr;
	logic          we_a, we_b;
	logic [CW-1:0] n_new;
	logic [SW-1:0] lo_w, hi_w, w2;
	logic [KEY_BITS-1:0] ka, kb;
	logic          goes_first, take_l;

	assign sel_l = p_q ? rd_b_l_q : rd_a_l_q;
	assign sel_r = p_q ? rd_b_r_q : rd_a_r_q;

	// Keys are remapped so that a plain unsigned compare gives the wanted order.
	always_comb begin
		ka = sel_l.key[KEY_BITS-1:0] ^ (cfg.signed_keys ? SIGN_MASK : '0);
		kb = sel_r.key[KEY_BITS-1:0] ^ (cfg.signed_keys ? SIGN_MASK : '0);
		goes_first = cfg.descending_order ? (ka >= kb) : (ka <= kb);
		take_l = (l_q < mid_q) && ((r_q >= hi_q) || goes_first);
	end

	always_comb begin
		lo_w  = SW'(lo_q) + SW'(w_q);
		hi_w  = lo_w + SW'(w_q);
		w2    = SW'(w_q) << 1;
		n_new = (head.kind == CMD_END) ? cnt_q : cnt_q + 1'b1;
	end

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		n_d       = n_q;
		lo_d      = lo_q;
		mid_d     = mid_q;
		hi_d      = hi_q;
		l_d       = l_q;
		r_d       = r_q;
		o_d       = o_q;
		k_d       = k_q;
		w_d       = w_q;
		p_d       = p_q;
		ovf_d     = ovf_q;
		pop       = 1'b0;
		done      = 1'b0;
		we_a      = 1'b0;
		we_b      = 1'b0;
		wr_addr   = cnt_q[AW-1:0];
		wr_rec    = head.rec;
		addr_l    = l_q[AW-1:0];
		addr_r    = r_q[AW-1:0];
		emit_go   = 1'b0;
		emit_last = 1'b0;
		unique case (state_q)
			BK_LOAD: begin
				if (!q_stat.empty) begin
					pop  = 1'b1;
					we_a = head.kind != CMD_END;
					if (head.kind == CMD_STORE) begin
						cnt_d = cnt_q + 1'b1;
					end else begin
						cnt_d = '0;
						n_d   = n_new;
						ovf_d = head.ovf;
						lo_d  = '0;
						o_d   = '0;
						k_d   = '0;
						w_d   = CW'(1);
						p_d   = 1'b0;
						if (n_new == '0) begin
							done = 1'b1;
						end else if (n_new == CW'(1)) begin
							state_d = BK_EMIT;
						end else begin
							state_d = BK_BLOCK;
						end
					end
				end
			end
			BK_BLOCK: begin
				if (lo_q >= n_q) begin
					// Pass finished: the sorted runs now sit in the other memory.
					p_d  = ~p_q;
					lo_d = '0;
					o_d  = '0;
					if (w2 >= SW'(n_q)) begin
						state_d = BK_EMIT;
					end else begin
						w_d = w2[CW-1:0];
					end
				end else begin
					mid_d   = (lo_w < SW'(n_q)) ? lo_w[CW-1:0] : n_q;
					hi_d    = (hi_w < SW'(n_q)) ? hi_w[CW-1:0] : n_q;
					l_d     = lo_q;
					r_d     = (lo_w < SW'(n_q)) ? lo_w[CW-1:0] : n_q;
					state_d = BK_READ;
				end
			end
			BK_READ: begin
				state_d = BK_MERGE;
			end
			BK_MERGE: begin
				if ((l_q == mid_q) && (r_q == hi_q)) begin
					lo_d    = hi_q;
					state_d = BK_BLOCK;
				end else begin
					wr_addr = o_q[AW-1:0];
					wr_rec  = take_l ? sel_l : sel_r;
					we_a    = p_q;
					we_b    = ~p_q;
					o_d     = o_q + 1'b1;
					if (take_l) begin
						l_d = l_q + 1'b1;
					end else begin
						r_d = r_q + 1'b1;
					end
					state_d = BK_READ;
				end
			end
			BK_EMIT: begin
				addr_l    = k_q[AW-1:0];
				emit_go   = 1'b1;
				emit_last = k_q == n_q - 1'b1;
				k_d       = k_q + 1'b1;
				if (emit_last) begin
					done    = 1'b1;
					state_d = BK_LOAD;
				end
			end
			default: begin
				state_d = BK_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we_a) begin
			mem_a[wr_addr] <= wr_rec;
		end
		if (we_b) begin
			mem_b[wr_addr] <= wr_rec;
		end
		rd_a_l_q <= mem_a[addr_l];
		rd_a_r_q <= mem_a[addr_r];
		rd_b_l_q <= mem_b[addr_l];
		rd_b_r_q <= mem_b[addr_r];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= BK_LOAD;
			cnt_q          <= '0;
			n_q            <= '0;
			lo_q           <= '0;
			mid_q          <= '0;
			hi_q           <= '0;
			l_q            <= '0;
			r_q            <= '0;
			o_q            <= '0;
			k_q            <= '0;
			w_q            <= '0;
			p_q            <= 1'b0;
			ovf_q          <= 1'b0;
			emit_vld_s1    <= 1'b0;
			emit_last_s1   <= 1'b0;
			emit_ovf_s1    <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_d;
			cnt_q          <= cnt_d;
			n_q            <= n_d;
			lo_q           <= lo_d;
			mid_q          <= mid_d;
			hi_q           <= hi_d;
			l_q            <= l_d;
			r_q            <= r_d;
			o_q            <= o_d;
			k_q            <= k_d;
			w_q            <= w_d;
			p_q            <= p_d;
			ovf_q          <= ovf_d;
			emit_vld_s1    <= emit_go;
			emit_last_s1   <= emit_last;
			emit_ovf_s1    <= ovf_q;
			result_valid_q <= emit_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		result_q.sorted_key       <= sel_l.key;
		result_q.sorted_payload   <= sel_l.payload;
		result_q.sorted_last      <= emit_last_s1;
		result_q.batch_overflowed <= emit_ovf_s1;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// The load counter never runs past the store.
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CW'(MAX_RECORDS))
		else $error("record count beyond capacity");

	// While merging, both run heads stay inside their runs.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_MERGE) |-> (l_q <= mid_q) && (r_q <= hi_q) && (hi_q <= n_q))
		else $error("merge pointer outside its run");

	// The write index of a pass equals the block start plus the records taken from the block.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_MERGE) |-> (SW'(o_q) + SW'(mid_q) == SW'(l_q) + SW'(r_q)))
		else $error("merge write index out of step");

	// Commands are only taken while loading.
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> (state_q == BK_LOAD))
		else $error("command popped outside load");

	// A result leaves through emit_vld_s1 and result_valid_q after its read was issued in the emit state.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> $past(state_q, 2) == BK_EMIT)
		else $error("result without an emit read");

endmodule

// ----- rtl/stable_merge_sorter.sv -----
// Top level of the stable merge sorter: configuration registers and the
// front, queue and back ends. Depends on sms_pkg, sms_front, sms_queue, sms_back.
//
//   Channel  Handshake              Payload
//   item     start / busy           item (in_item_t)
//   config   cfg_valid / cfg_ready  cfg_index, cfg_data
//   result   result_valid strobe    result (out_item_t)
//
// Records are loaded from the queue into the first record memory. After the last
// record, the back end runs ceil(log2 n) bottom-up merge passes. Each block pair takes
// a BK_BLOCK setup, a BK_READ and BK_MERGE step per record (the record memories are
// read through a register) and a closing BK_READ and BK_MERGE; each pass closes in
// BK_BLOCK. Then one record per cycle is emitted through the registered memory read
// and the result register. busy stays high from the last transfer of a batch until
// the read of its final record is issued, so it drops in the cycle before the final
// result appears. Reset clears all control state; results are never held back.
module stable_merge_sorter import sms_pkg::*; #(
	parameter int MAX_RECORDS = MAX_RECORDS_DEF,
	parameter int KEY_BITS    = KEY_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  in_item_t   item,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic       cfg_data,
	output logic       result_valid,
	output out_item_t  result
);

	cfg_t    cfg_q;
	q_stat_t q_stat;
	cmd_t    push_cmd;
	cmd_t    head;
	logic    push;
	logic    pop;
	logic    back_done;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_DESCENDING: cfg_q.descending_order <= cfg_data;
				CFG_SIGNED:     cfg_q.signed_keys      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	sms_front #(
		.MAX_RECORDS (MAX_RECORDS),
		.KEY_BITS    (KEY_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.busy      (busy),
		.q_stat    (q_stat),
		.back_done (back_done),
		.push      (push),
		.cmd       (push_cmd)
	);

	sms_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.stat     (q_stat)
	);

	sms_back #(
		.MAX_RECORDS (MAX_RECORDS),
		.KEY_BITS    (KEY_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_stat       (q_stat),
		.head         (head),
		.pop          (pop),
		.done         (back_done),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule
